// ===== hw/rtl/bis_pkg.sv =====
// bis_pkg: types, codes and default sizes shared by the bilinear image scaler
// depends on nothing; imported by bilinear_image_scaler_core
package bis_pkg;

	localparam int DEF_MAX_SRC_WIDTH    = 256;
	localparam int DEF_MAX_SRC_HEIGHT   = 256;
	localparam int DEF_WEIGHT_FRAC_BITS = 16;

	// memory port slots taken by one query (four neighbor reads)
	localparam int QUERY_SLOTS = 4;

	localparam int CFG_DATA_W  = 13;
	localparam int CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_DST_WIDTH  = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_DST_HEIGHT = 2'd3;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic        op;
		logic [11:0] col;
		logic [11:0] row;
		logic [7:0]  in_red;
		logic [7:0]  in_green;
		logic [7:0]  in_blue;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
	} out_item_t;

endpackage

// ===== hw/rtl/bilinear_image_scaler_core.sv =====
// bilinear_image_scaler_core: corner-aligned bilinear scaler over an on-chip image store
// depends on bis_pkg for item types, register indexes and default sizes
//
// A load does not raise busy: start may be high again in the next cycle. A query holds the
// single image-store port for its four neighbor reads (one neighbor pixel per cycle), so busy
// stays high after a query transfer until those reads have their port slots; a new item is not
// taken before then. The result of a query appears with done after the capture, position,
// read and blend registers and cannot be stalled; later items keep flowing while earlier
// results are still being blended. After reset and after every register write the scale
// ratios are recomputed by a bit-serial divider: a setup step, then one quotient bit per
// cycle for each of the log2(MAX_SRC)+WEIGHT_FRAC_BITS quotient bits, and busy stays high
// until the division ends. Loads outside the source size are dropped; store entries read
// before being written return arbitrary data.
module bilinear_image_scaler_core #(
	parameter int MAX_SRC_WIDTH    = bis_pkg::DEF_MAX_SRC_WIDTH,
	parameter int MAX_SRC_HEIGHT   = bis_pkg::DEF_MAX_SRC_HEIGHT,
	parameter int WEIGHT_FRAC_BITS = bis_pkg::DEF_WEIGHT_FRAC_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  bis_pkg::in_item_t                   item,
	output logic                                done,
	output bis_pkg::out_item_t                  result,
	input  logic                                cfg_we,
	input  logic [bis_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [bis_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import bis_pkg::*;

	localparam int F    = WEIGHT_FRAC_BITS;
	localparam int SWB  = $clog2(MAX_SRC_WIDTH);
	localparam int SHB  = $clog2(MAX_SRC_HEIGHT);
	localparam int NWX  = SWB + F;
	localparam int NWY  = SHB + F;
	localparam int NW   = (NWX > NWY) ? NWX : NWY;
	localparam int CW   = $clog2(NW + 1);
	localparam int PW   = 12 + NW;
	localparam int DEP  = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
	localparam int AW   = $clog2(DEP);
	localparam int TW   = F + 8;
	localparam int VW   = 2 * F + 8;

	// configuration registers
	logic [8:0]  src_w_q, src_h_q;
	logic [12:0] dst_w_q, dst_h_q;

	// effective sizes
	logic [12:0]    eff_w, eff_h;
	logic [SWB-1:0] srcm1_x;
	logic [SHB-1:0] srcm1_y;

	// ratio divider
	logic          dstart_q;
	logic [CW-1:0] dcnt_q;
	logic [NW-1:0] nqx_q, nqy_q;
	logic [13:0]   remx_q, remy_q;
	logic [12:0]   dvx, dvy;
	logic [13:0]   trialx, trialy;
	logic          gex, gey;
	logic [NW-1:0] ratio_x_q, ratio_y_q;

	// handshake
	logic       accept;
	logic [1:0] cool_q;
	logic       ld_ok;

	// stage 1
	logic          v_s1, op_s1, we_s1;
	logic [11:0]   col_s1, row_s1;
	logic [23:0]   data_s1;
	logic [AW-1:0] waddr_s1;

	// stage 2
	logic          v_s2, op_s2, we_s2;
	logic [PW-1:0] posx_s2, posy_s2;
	logic [23:0]   data_s2;
	logic [AW-1:0] waddr_s2;
	logic [PW-1:0] maxx, maxy, pcx, pcy;
	logic [SWB-1:0] lox, hix;
	logic [SHB-1:0] loy, hiy;

	// stage 3, memory port
	logic           we_s3;
	logic [23:0]    data_s3;
	logic [AW-1:0]  waddr_s3;
	logic [SWB-1:0] x0_s3, x1_s3;
	logic [SHB-1:0] y0_s3, y1_s3;
	logic [F-1:0]   wx_s3, wy_s3;
	logic           rd_act_q, rd_act_d_q;
	logic [1:0]     ph_q, ph_d_q;
	logic [SWB-1:0] rx;
	logic [SHB-1:0] ry;
	logic [AW-1:0]  raddr;
	logic [23:0]    mem [DEP];
	logic [23:0]    rdata_q;
	logic [23:0]    pix_q [3];
	logic [F-1:0]   wx_q, wy_q;

	// blend
	logic [F:0]    owx, owy;
	logic          v_b1;
	logic [TW-1:0] top_b1 [3];
	logic [TW-1:0] bot_b1 [3];
	logic [F-1:0]  wy_b1;
	logic [TW-1:0] top_c [3];
	logic [TW-1:0] bot_c [3];
	logic [VW-1:0] v_c [3];
	logic [7:0]    ch_c [3];

	assign eff_w = (src_w_q == 9'd0) ? 13'd1 :
		(13'(src_w_q) > 13'(MAX_SRC_WIDTH)) ? 13'(MAX_SRC_WIDTH) : 13'(src_w_q);
	assign eff_h = (src_h_q == 9'd0) ? 13'd1 :
		(13'(src_h_q) > 13'(MAX_SRC_HEIGHT)) ? 13'(MAX_SRC_HEIGHT) : 13'(src_h_q);
	assign srcm1_x = SWB'(eff_w - 13'd1);
	assign srcm1_y = SHB'(eff_h - 13'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= 9'd256;
			src_h_q <= 9'd256;
			dst_w_q <= 13'd256;
			dst_h_q <= 13'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SRC_WIDTH:  src_w_q <= cfg_data[8:0];
				CFG_SRC_HEIGHT: src_h_q <= cfg_data[8:0];
				CFG_DST_WIDTH:  dst_w_q <= cfg_data;
				CFG_DST_HEIGHT: dst_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// restoring divider, both axes side by side, one quotient bit per cycle
	assign dvx    = dst_w_q - 13'd1;
	assign dvy    = dst_h_q - 13'd1;
	assign trialx = {remx_q[12:0], nqx_q[NW-1]};
	assign trialy = {remy_q[12:0], nqy_q[NW-1]};
	assign gex    = trialx >= {1'b0, dvx};
	assign gey    = trialy >= {1'b0, dvy};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dstart_q <= 1'b1;
			dcnt_q   <= '0;
		end else if (cfg_we) begin
			dstart_q <= 1'b1;
			dcnt_q   <= '0;
		end else if (dstart_q) begin
			dstart_q <= 1'b0;
			dcnt_q   <= CW'(NW);
		end else if (dcnt_q != '0) begin
			dcnt_q <= dcnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (dstart_q) begin
			nqx_q  <= NW'({srcm1_x, {F{1'b0}}});
			nqy_q  <= NW'({srcm1_y, {F{1'b0}}});
			remx_q <= '0;
			remy_q <= '0;
		end else if (dcnt_q != '0) begin
			nqx_q  <= {nqx_q[NW-2:0], gex};
			nqy_q  <= {nqy_q[NW-2:0], gey};
			remx_q <= gex ? (trialx - {1'b0, dvx}) : trialx;
			remy_q <= gey ? (trialy - {1'b0, dvy}) : trialy;
			if (dcnt_q == CW'(1)) begin
				ratio_x_q <= (dst_w_q < 13'd2) ? '0 : {nqx_q[NW-2:0], gex};
				ratio_y_q <= (dst_h_q < 13'd2) ? '0 : {nqy_q[NW-2:0], gey};
			end
		end
	end

	assign busy   = dstart_q | (dcnt_q != '0) | (cool_q != 2'd0);
	assign accept = start & ~busy;
	assign ld_ok  = ({1'b0, item.col} < eff_w) && ({1'b0, item.row} < eff_h);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cool_q <= 2'd0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			we_s3  <= 1'b0;
		end else begin
			if (accept && item.op == OP_QUERY) begin
				cool_q <= 2'(QUERY_SLOTS - 1);
			end else if (cool_q != 2'd0) begin
				cool_q <= cool_q - 2'd1;
			end
			v_s1  <= accept;
			v_s2  <= v_s1;
			we_s3 <= v_s2 && op_s2 == OP_LOAD && we_s2;
		end
	end

	// stage 1: capture the transfer; range check uses the current sizes, write address the maximum width
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= item.op;
			we_s1    <= ld_ok;
			col_s1   <= item.col;
			row_s1   <= item.row;
			data_s1  <= {item.in_red, item.in_green, item.in_blue};
			waddr_s1 <= AW'(item.row[SHB-1:0]) * AW'(MAX_SRC_WIDTH) + AW'(item.col[SWB-1:0]);
		end
	end

	// stage 2: source positions
	always_ff @(posedge clk) begin
		op_s2    <= op_s1;
		we_s2    <= we_s1;
		data_s2  <= data_s1;
		waddr_s2 <= waddr_s1;
		posx_s2  <= PW'(col_s1) * PW'(ratio_x_q);
		posy_s2  <= PW'(row_s1) * PW'(ratio_y_q);
	end

	// clamp to the last pixel, split into index and weight
	assign maxx = PW'({srcm1_x, {F{1'b0}}});
	assign maxy = PW'({srcm1_y, {F{1'b0}}});
	assign pcx  = (posx_s2 > maxx) ? maxx : posx_s2;
	assign pcy  = (posy_s2 > maxy) ? maxy : posy_s2;
	assign lox  = pcx[F+SWB-1:F];
	assign loy  = pcy[F+SHB-1:F];
	assign hix  = (lox == srcm1_x) ? lox : lox + SWB'(1);
	assign hiy  = (loy == srcm1_y) ? loy : loy + SHB'(1);

	always_ff @(posedge clk) begin
		if (v_s2) begin
			data_s3  <= data_s2;
			waddr_s3 <= waddr_s2;
			x0_s3    <= lox;
			x1_s3    <= hix;
			y0_s3    <= loy;
			y1_s3    <= hiy;
			wx_s3    <= pcx[F-1:0];
			wy_s3    <= pcy[F-1:0];
		end
	end

	// read sequencer: tl, tr, bl, br on consecutive cycles
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_act_q   <= 1'b0;
			ph_q       <= 2'd0;
			rd_act_d_q <= 1'b0;
			ph_d_q     <= 2'd0;
		end else begin
			if (v_s2 && op_s2 == OP_QUERY) begin
				rd_act_q <= 1'b1;
				ph_q     <= 2'd0;
			end else if (rd_act_q) begin
				ph_q <= ph_q + 2'd1;
				if (ph_q == 2'd3) begin
					rd_act_q <= 1'b0;
				end
			end
			rd_act_d_q <= rd_act_q;
			ph_d_q     <= ph_q;
		end
	end

	assign rx    = ph_q[0] ? x1_s3 : x0_s3;
	assign ry    = ph_q[1] ? y1_s3 : y0_s3;
	assign raddr = AW'(ry) * AW'(MAX_SRC_WIDTH) + AW'(rx);

	// single-port image store
	always_ff @(posedge clk) begin
		if (we_s3) begin
			mem[waddr_s3] <= data_s3;
		end else if (rd_act_q) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_act_q && ph_q == 2'd3) begin
			wx_q <= wx_s3;
			wy_q <= wy_s3;
		end
		if (rd_act_d_q && ph_d_q != 2'd3) begin
			pix_q[ph_d_q] <= rdata_q;
		end
	end

	// horizontal then vertical blend per channel
	assign owx = {1'b1, {F{1'b0}}} - (F+1)'(wx_q);
	assign owy = {1'b1, {F{1'b0}}} - (F+1)'(wy_b1);

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			top_c[c] = TW'((F+9)'(pix_q[0][8*(2-c) +: 8]) * (F+9)'(owx)
				+ (F+9)'(pix_q[1][8*(2-c) +: 8]) * (F+9)'(wx_q));
			bot_c[c] = TW'((F+9)'(pix_q[2][8*(2-c) +: 8]) * (F+9)'(owx)
				+ (F+9)'(rdata_q[8*(2-c) +: 8]) * (F+9)'(wx_q));
			v_c[c]   = VW'(top_b1[c]) * VW'(owy) + VW'(bot_b1[c]) * VW'(wy_b1);
			ch_c[c]  = v_c[c][VW-1:2*F];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_b1 <= rd_act_d_q && ph_d_q == 2'd3;
			done <= v_b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_act_d_q && ph_d_q == 2'd3) begin
			top_b1 <= top_c;
			bot_b1 <= bot_c;
			wy_b1  <= wy_q;
		end
		if (v_b1) begin
			result.out_red   <= ch_c[0];
			result.out_green <= ch_c[1];
			result.out_blue  <= ch_c[2];
		end
	end

`ifndef SYNTHESIS
	// a load write never lands on a cycle the read sequencer owns
	a_port_free: assert property (@(posedge clk) disable iff (!arst_n)
		!(we_s3 && rd_act_q))
		else $error("image store write collides with a query read");

	// no transfer while the ratios are being recomputed
	a_ratio_ready: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (dcnt_q == '0) && !dstart_q)
		else $error("transfer taken during ratio division");

	// each result follows the last neighbor read through the delayed read flag, v_b1 and done registers
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(rd_act_q && ph_q == 2'd3, 3))
		else $error("result without a completed read sequence");

	// a query transfer keeps busy up for the rest of its port slots
	a_query_hold: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.op == OP_QUERY |=> busy)
		else $error("busy dropped right after a query transfer");
`endif

endmodule

// ===== tb/bis_checker.sv =====
// bis_checker: predicts each query of the bilinear image scaler and checks every result
// depends on bis_pkg; sits beside bilinear_image_scaler_core and only watches its ports
module bis_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            busy,
	input  bis_pkg::in_item_t               item,
	input  logic                            done,
	input  bis_pkg::out_item_t              result,
	input  logic                            cfg_we,
	input  logic [bis_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [bis_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                              pending,
	output int                              fails
);
	import bis_pkg::*;

	localparam int FRAC      = DEF_WEIGHT_FRAC_BITS;
	localparam int DUE_DEPTH = 16;

	logic [23:0] image_store [DEF_MAX_SRC_WIDTH*DEF_MAX_SRC_HEIGHT];
	logic [8:0]  src_w, src_h;
	logic [12:0] dst_w, dst_h;
	// expected pixels in query order
	out_item_t   due_fifo [DUE_DEPTH];
	logic [3:0]  due_wr, due_rd;
	int          due_count;

	function automatic int unsigned eff_size(logic [8:0] v, int unsigned maxv);
		if (v == 0) return 1;
		if (v > maxv) return maxv;
		return 32'(v);
	endfunction

	// floor index, clamped neighbor and fraction weight along one axis
	function automatic void map_axis(input int unsigned coord, input int unsigned src,
			input logic [12:0] dst, output int unsigned lo, output int unsigned hi,
			output longint unsigned w);
		longint unsigned ratio, pos, maxpos;
		maxpos = longint'(src - 1) << FRAC;
		ratio = (dst > 1) ? maxpos / (dst - 1) : 0;
		pos = coord * ratio;
		if (pos > maxpos) pos = maxpos;
		lo = 32'(pos >> FRAC);
		w = pos & ((64'd1 << FRAC) - 1);
		hi = (lo + 1 < src) ? lo + 1 : src - 1;
	endfunction

	function automatic logic [7:0] mix(logic [7:0] tl, logic [7:0] tr, logic [7:0] bl,
			logic [7:0] br, longint unsigned wx, longint unsigned wy);
		longint unsigned one, top, bot;
		one = 64'd1 << FRAC;
		top = tl * (one - wx) + tr * wx;
		bot = bl * (one - wx) + br * wx;
		return 8'((top * (one - wy) + bot * wy) >> (2 * FRAC));
	endfunction

	function automatic out_item_t scaled_pixel(in_item_t q);
		int unsigned x0, x1, y0, y1;
		longint unsigned wx, wy;
		logic [23:0] tl, tr, bl, br;
		out_item_t p;
		map_axis(q.col, eff_size(src_w, DEF_MAX_SRC_WIDTH), dst_w, x0, x1, wx);
		map_axis(q.row, eff_size(src_h, DEF_MAX_SRC_HEIGHT), dst_h, y0, y1, wy);
		tl = image_store[y0 * DEF_MAX_SRC_WIDTH + x0];
		tr = image_store[y0 * DEF_MAX_SRC_WIDTH + x1];
		bl = image_store[y1 * DEF_MAX_SRC_WIDTH + x0];
		br = image_store[y1 * DEF_MAX_SRC_WIDTH + x1];
		p.out_red   = mix(tl[23:16], tr[23:16], bl[23:16], br[23:16], wx, wy);
		p.out_green = mix(tl[15:8], tr[15:8], bl[15:8], br[15:8], wx, wy);
		p.out_blue  = mix(tl[7:0], tr[7:0], bl[7:0], br[7:0], wx, wy);
		return p;
	endfunction

	assign pending = due_count;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w = 256;
			src_h = 256;
			dst_w = 256;
			dst_h = 256;
			fails = 0;
			due_wr = '0;
			due_rd = '0;
			due_count = 0;
		end else begin
			if (done) begin
				if (due_count == 0) begin
					$error("result with nothing expected: %h", result);
					fails++;
				end else begin
					out_item_t want;
					want = due_fifo[due_rd];
					due_rd++;
					due_count--;
					if (result.out_red !== want.out_red) begin
						$error("out_red expected %0d got %0d", want.out_red, result.out_red);
						fails++;
					end
					if (result.out_green !== want.out_green) begin
						$error("out_green expected %0d got %0d", want.out_green,
							result.out_green);
						fails++;
					end
					if (result.out_blue !== want.out_blue) begin
						$error("out_blue expected %0d got %0d", want.out_blue,
							result.out_blue);
						fails++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_SRC_WIDTH: src_w = cfg_data[8:0];
					CFG_SRC_HEIGHT: src_h = cfg_data[8:0];
					CFG_DST_WIDTH: dst_w = cfg_data;
					CFG_DST_HEIGHT: dst_h = cfg_data;
					default: ;
				endcase
			end
			if (start && !busy) begin
				if (item.op == OP_QUERY) begin
					due_fifo[due_wr] = scaled_pixel(item);
					due_wr++;
					due_count++;
				end else if (item.col < eff_size(src_w, DEF_MAX_SRC_WIDTH) &&
						item.row < eff_size(src_h, DEF_MAX_SRC_HEIGHT)) begin
					image_store[item.row * DEF_MAX_SRC_WIDTH + item.col] =
						{item.in_red, item.in_green, item.in_blue};
				end
			end
		end
	end

endmodule

// ===== tb/tb.sv =====
// tb: stimulus and verdict for bilinear_image_scaler_core
// depends on bis_pkg and bis_checker, which predicts and compares every result
module tb;
	import bis_pkg::*;

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	in_item_t               item;
	logic                   done;
	out_item_t              result;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	int                     pending;
	int                     fails;
	int                     sent;
	int                     cycles;
	int unsigned            eff_w, eff_h, cur_dw, cur_dh;

	bilinear_image_scaler_core u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	bis_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .pending(pending), .fails(fails)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 600000) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// each call starts and ends at a falling edge; start stays high for the next transfer
	task automatic send(input logic op, input int unsigned c, input int unsigned r);
		item.op = op;
		item.col = 12'(c);
		item.row = 12'(r);
		item.in_red = 8'($urandom_range(0, 255));
		item.in_green = 8'($urandom_range(0, 255));
		item.in_blue = 8'($urandom_range(0, 255));
		start = 1;
		while (busy) @(negedge clk);
		@(negedge clk);
		if (op == OP_QUERY || (c < eff_w && r < eff_h)) sent++;
	endtask

	task automatic maybe_idle();
		if (sent < 900 && $urandom_range(0, 5) == 0) begin
			start = 0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
	endtask

	task automatic drain();
		start = 0;
		while (pending != 0) @(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic configure(input int unsigned sw, input int unsigned sh,
			input int unsigned dw, input int unsigned dh);
		drain();
		cfg_we = 1;
		cfg_index = CFG_SRC_WIDTH;  cfg_data = 13'(sw); @(negedge clk);
		cfg_index = CFG_SRC_HEIGHT; cfg_data = 13'(sh); @(negedge clk);
		cfg_index = CFG_DST_WIDTH;  cfg_data = 13'(dw); @(negedge clk);
		cfg_index = CFG_DST_HEIGHT; cfg_data = 13'(dh); @(negedge clk);
		cfg_we = 0;
		eff_w = (sw[8:0] == 0) ? 1 : (sw[8:0] > 256) ? 256 : sw[8:0];
		eff_h = (sh[8:0] == 0) ? 1 : (sh[8:0] > 256) ? 256 : sh[8:0];
		cur_dw = (dw == 0) ? 1 : dw;
		cur_dh = (dh == 0) ? 1 : dh;
	endtask

	// fill the whole source first so no query reads an unwritten pixel
	task automatic run_phase(input int unsigned sw, input int unsigned sh,
			input int unsigned dw, input int unsigned dh, input int queries);
		configure(sw, sh, dw, dh);
		for (int unsigned r = 0; r < eff_h; r++) begin
			for (int unsigned c = 0; c < eff_w; c++) begin
				maybe_idle();
				send(OP_LOAD, c, r);
			end
		end
		send(OP_QUERY, 0, 0);
		send(OP_QUERY, cur_dw - 1, cur_dh - 1);
		send(OP_QUERY, 4095, 4095);
		send(OP_LOAD, eff_w, $urandom_range(0, 4095));
		send(OP_LOAD, $urandom_range(0, 4095), eff_h);
		for (int i = 0; i < queries; i++) begin
			maybe_idle();
			case ($urandom_range(0, 9))
				0: send(OP_LOAD, $urandom_range(0, eff_w - 1), $urandom_range(0, eff_h - 1));
				1: send(OP_LOAD, $urandom_range(0, 4095), $urandom_range(0, 4095));
				2: send(OP_QUERY, $urandom_range(0, 4095), $urandom_range(0, 4095));
				default: send(OP_QUERY, $urandom_range(0, cur_dw - 1),
					$urandom_range(0, cur_dh - 1));
			endcase
			if (i == queries / 2 && $urandom_range(0, 1) == 0) drain();
		end
	endtask

	initial begin
		arst_n = 0;
		start = 0;
		item = '0;
		cfg_we = 0;
		cfg_index = CFG_SRC_WIDTH;
		cfg_data = '0;
		sent = 0;
		eff_w = 256;
		eff_h = 256;
		repeat (10) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		run_phase(4, 3, 7, 5, 6);
		run_phase(4, 3, 1, 0, 3);
		run_phase(2, 2, 4096, 4096, 6);
		run_phase(0, 0, 3, 3, 2);
		run_phase(511, 1, 8191, 2, 10);
		run_phase(1, 256, 3, 4096, 10);
		while (sent < 1000) begin
			if ($urandom_range(0, 3) == 0)
				run_phase($urandom_range(1, 16), $urandom_range(1, 16),
					$urandom_range(1, 4096), $urandom_range(1, 4096), 60);
			else
				run_phase($urandom_range(1, 16), $urandom_range(1, 16),
					$urandom_range(1, 64), $urandom_range(1, 64), 60);
		end
		drain();
		if (fails == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/bis_pkg.sv
hw/rtl/bilinear_image_scaler_core.sv
tb/bis_checker.sv
tb/tb.sv
